// ===== rtl/coc_pkg.sv =====
// ----------------------------------------------------------------------------
// coc_pkg: shared types and constants for the cursor overlay compositor
// Pointer art, hotspots, pixel colors, register indexes and field widths.
// ----------------------------------------------------------------------------
package coc_pkg;

   localparam int COORD_BITS_DEF = 12;   // default pixel coordinate width
   localparam int SIZE_BITS      = 12;   // screen size register width
   localparam int POS_BITS       = 16;   // signed cursor position register
   localparam int ORG_BITS       = POS_BITS + 1;  // window origin, signed
   localparam int PIX_BITS       = 16;
   localparam int CURSOR_SIDE    = 16;
   localparam int SIDE_BITS      = $clog2(CURSOR_SIDE);
   localparam int SHAPE_ROWS     = 2 * CURSOR_SIDE;
   localparam int ROW_IDX_BITS   = $clog2(SHAPE_ROWS);
   localparam int HOT_BITS       = 3;

   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [HOT_BITS-1:0]  HOT_ARROW     = 3'd0;
   localparam logic [HOT_BITS-1:0]  HOT_HOURGLASS = 3'd7;

   localparam logic [PIX_BITS-1:0]  PIX_WHITE = 16'hFFFF;
   localparam logic [PIX_BITS-1:0]  PIX_BLACK = 16'h0000;

   localparam logic [SIZE_BITS-1:0] RESET_SCREEN_W = 12'd320;
   localparam logic [SIZE_BITS-1:0] RESET_SCREEN_H = 12'd240;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_CURSOR_X      = 3'd0,
      REG_CURSOR_Y      = 3'd1,
      REG_SCREEN_WIDTH  = 3'd2,
      REG_SCREEN_HEIGHT = 3'd3,
      REG_SHAPE_SELECT  = 3'd4,
      REG_CURSOR_ENABLE = 3'd5
   } coc_reg_idx_type;

   // Rows 0..15 arrow, 16..31 hourglass; bit c is shape column c.
   localparam logic [CURSOR_SIDE-1:0] OPAQUE_ROWS [0:SHAPE_ROWS-1] = '{
      16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F, 16'h007F, 16'h00FF,
      16'h01FF, 16'h03FF, 16'h07FF, 16'h007F, 16'h00F7, 16'h01E3, 16'h03C1, 16'h0180,
      16'h0FFC, 16'h0FFC, 16'h0FFC, 16'h0FFC, 16'h07F8, 16'h03F0, 16'h01E0, 16'h01E0,
      16'h01E0, 16'h03F0, 16'h07F8, 16'h0FFC, 16'h0FFC, 16'h0FFC, 16'h0000, 16'h0000
   };

   localparam logic [CURSOR_SIDE-1:0] WHITE_ROWS [0:SHAPE_ROWS-1] = '{
      16'h0000, 16'h0000, 16'h0002, 16'h0006, 16'h000E, 16'h001E, 16'h003E, 16'h007E,
      16'h00FE, 16'h01FE, 16'h003E, 16'h0036, 16'h0062, 16'h00C0, 16'h0180, 16'h0000,
      16'h0000, 16'h07F8, 16'h07F8, 16'h0408, 16'h03F0, 16'h01E0, 16'h00C0, 16'h00C0,
      16'h00C0, 16'h0120, 16'h0210, 16'h0408, 16'h0408, 16'h0000, 16'h0000, 16'h0000
   };

endpackage

// ===== rtl/coc_if.sv =====
// ----------------------------------------------------------------------------
// coc_if: request and response channels of the cursor overlay compositor
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface coc_req_if #(
   parameter int COORD_BITS = coc_pkg::COORD_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [COORD_BITS-1:0]         pixel_col;
   logic [COORD_BITS-1:0]         pixel_row;
   logic [coc_pkg::PIX_BITS-1:0]  background;

   modport source (output valid, output pixel_col, output pixel_row,
                   output background, input ready);
   modport sink   (input valid, input pixel_col, input pixel_row,
                   input background, output ready);
endinterface

interface coc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [coc_pkg::PIX_BITS-1:0]  pixel_out;
   logic                          covered;

   modport source (output valid, output pixel_out, output covered, input ready);
   modport sink   (input valid, input pixel_out, input covered, output ready);
endinterface

// ===== rtl/coc_origin.sv =====
// ----------------------------------------------------------------------------
// coc_origin: pointer window origin along one axis
// Clamps the requested position onto the screen, subtracts the hotspot and
// registers the result.
// ----------------------------------------------------------------------------
module coc_origin #(
   parameter int COORD_BITS = coc_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic signed [coc_pkg::POS_BITS-1:0]  pos,
   input  logic [COORD_BITS-1:0]                size,
   input  logic [coc_pkg::HOT_BITS-1:0]         hot,
   output logic signed [coc_pkg::ORG_BITS-1:0]  org_ff
);
   import coc_pkg::*;

   logic [POS_BITS-1:0]        size_ext;
   logic                       over;
   logic [POS_BITS-1:0]        clamped;
   logic signed [ORG_BITS-1:0] org_in;

   assign size_ext = {{(POS_BITS-COORD_BITS){1'b0}}, size};
   // position is nonnegative here whenever over matters
   assign over     = (|size) && (pos[POS_BITS-2:0] >= size_ext[POS_BITS-2:0]);

   always_comb begin
      if (pos[POS_BITS-1]) begin
         clamped = '0;
      end else if (over) begin
         clamped = size_ext - POS_BITS'(1);
      end else begin
         clamped = pos;
      end
      org_in = $signed({1'b0, clamped}) - $signed({{(ORG_BITS-HOT_BITS){1'b0}}, hot});
   end

   always_ff @(posedge clock) begin
      org_ff <= org_in;
   end

endmodule

// ===== rtl/cursor_overlay_compositor.sv =====
// ----------------------------------------------------------------------------
// cursor_overlay_compositor: 16x16 hardware pointer over a pixel stream
// Three-stage pipeline that replaces background pixels under the pointer.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock and returns one result per request, in
// order (stage 1 holds the pixel, stage 2 does the window test, stage 3
// reads the mask and is the output register). With the response side ready,
// throughput is one pixel per cycle with no gaps; a stall there backs up
// through the stages without dropping anything, and empty stages fill while
// the output waits. Registers must be written through the csr_ port only
// while no request is in flight; the block does not enforce it. The clamped
// window origin is recomputed after a write, before any new request reaches
// it. Pointer art is built in: shape 0 is an arrow (hotspot 0,0), shape 1 an
// hourglass (hotspot 7,7). A screen size of zero lifts that edge's clamp.
// ----------------------------------------------------------------------------
module cursor_overlay_compositor #(
   parameter int COORD_BITS = coc_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   coc_req_if.sink                             req_ch,
   coc_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [coc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [coc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import coc_pkg::*;

   localparam int D_W = ORG_BITS + 1;   // column minus origin, signed

   // ---- configuration registers ----
   logic signed [POS_BITS-1:0] cursor_x_ff, cursor_y_ff;
   logic [SIZE_BITS-1:0]       screen_w_ff, screen_h_ff;
   logic                       shape_sel_ff, cursor_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         screen_w_ff  <= RESET_SCREEN_W;
         screen_h_ff  <= RESET_SCREEN_H;
         shape_sel_ff <= 1'b0;
         cursor_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (coc_reg_idx_type'(csr_index))
            REG_CURSOR_X:      cursor_x_ff  <= $signed(csr_wdata[POS_BITS-1:0]);
            REG_CURSOR_Y:      cursor_y_ff  <= $signed(csr_wdata[POS_BITS-1:0]);
            REG_SCREEN_WIDTH:  screen_w_ff  <= csr_wdata[SIZE_BITS-1:0];
            REG_SCREEN_HEIGHT: screen_h_ff  <= csr_wdata[SIZE_BITS-1:0];
            REG_SHAPE_SELECT:  shape_sel_ff <= csr_wdata[0];
            REG_CURSOR_ENABLE: cursor_en_ff <= csr_wdata[0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ---- window origin (screen size seen through COORD_BITS) ----
   logic [COORD_BITS-1:0]      size_w, size_h;
   logic [HOT_BITS-1:0]        hot;
   logic signed [ORG_BITS-1:0] org_x_ff, org_y_ff;

   for (genvar g = 0; g < COORD_BITS; g++) begin : g_size
      if (g < SIZE_BITS) begin : g_bit
         assign size_w[g] = screen_w_ff[g];
         assign size_h[g] = screen_h_ff[g];
      end else begin : g_pad
         assign size_w[g] = 1'b0;
         assign size_h[g] = 1'b0;
      end
   end

   assign hot = shape_sel_ff ? HOT_HOURGLASS : HOT_ARROW;

   coc_origin #(.COORD_BITS(COORD_BITS)) u_org_x (
      .clock  (clock),
      .pos    (cursor_x_ff),
      .size   (size_w),
      .hot    (hot),
      .org_ff (org_x_ff)
   );

   coc_origin #(.COORD_BITS(COORD_BITS)) u_org_y (
      .clock  (clock),
      .pos    (cursor_y_ff),
      .size   (size_h),
      .hot    (hot),
      .org_ff (org_y_ff)
   );

   // ---- pipeline flow control: a stage loads when empty or draining ----
   logic s1_v_ff, s2_v_ff, s3_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready     = !s3_v_ff || rsp_ch.ready;
   assign s2_ready     = !s2_v_ff || s3_ready;
   assign s1_ready     = !s1_v_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   // ---- stage 1: captured request ----
   logic [COORD_BITS-1:0] s1_col_ff, s1_col_in;
   logic [COORD_BITS-1:0] s1_row_ff, s1_row_in;
   logic [PIX_BITS-1:0]   s1_bg_ff,  s1_bg_in;

   always_comb begin
      s1_v_in   = s1_v_ff;
      s1_col_in = s1_col_ff;
      s1_row_in = s1_row_ff;
      s1_bg_in  = s1_bg_ff;
      if (s1_ready) begin
         s1_v_in   = req_ch.valid;
         s1_col_in = req_ch.pixel_col;
         s1_row_in = req_ch.pixel_row;
         s1_bg_in  = req_ch.background;
      end
   end

   // ---- stage 2: offset into the pointer window ----
   logic signed [D_W-1:0] dx, dy;
   logic                  s2_hit_ff, s2_hit_in;
   logic [SIDE_BITS-1:0]  s2_dx_ff,  s2_dx_in;
   logic [SIDE_BITS-1:0]  s2_dy_ff,  s2_dy_in;
   logic [PIX_BITS-1:0]   s2_bg_ff,  s2_bg_in;

   assign dx = $signed({{(D_W-COORD_BITS){1'b0}}, s1_col_ff}) - {org_x_ff[ORG_BITS-1], org_x_ff};
   assign dy = $signed({{(D_W-COORD_BITS){1'b0}}, s1_row_ff}) - {org_y_ff[ORG_BITS-1], org_y_ff};

   always_comb begin
      s2_v_in   = s2_v_ff;
      s2_hit_in = s2_hit_ff;
      s2_dx_in  = s2_dx_ff;
      s2_dy_in  = s2_dy_ff;
      s2_bg_in  = s2_bg_ff;
      if (s2_ready) begin
         s2_v_in   = s1_v_ff;
         // inside the window: offset in [0, CURSOR_SIDE) on both axes
         s2_hit_in = cursor_en_ff && (dx[D_W-1:SIDE_BITS] == '0)
                                  && (dy[D_W-1:SIDE_BITS] == '0);
         s2_dx_in  = dx[SIDE_BITS-1:0];
         s2_dy_in  = dy[SIDE_BITS-1:0];
         s2_bg_in  = s1_bg_ff;
      end
   end

   // ---- stage 3: mask lookup, output register ----
   logic [ROW_IDX_BITS-1:0] row_idx;
   logic                    op_bit, wh_bit;
   logic                    s3_cov_ff, s3_cov_in;
   logic [PIX_BITS-1:0]     s3_pix_ff, s3_pix_in;

   assign row_idx = {shape_sel_ff, s2_dy_ff};
   assign op_bit  = OPAQUE_ROWS[row_idx][s2_dx_ff];
   assign wh_bit  = WHITE_ROWS[row_idx][s2_dx_ff];

   always_comb begin
      s3_v_in   = s3_v_ff;
      s3_cov_in = s3_cov_ff;
      s3_pix_in = s3_pix_ff;
      if (s3_ready) begin
         s3_v_in   = s2_v_ff;
         s3_cov_in = s2_hit_ff && op_bit;
         if (s2_hit_ff && op_bit) begin
            s3_pix_in = wh_bit ? PIX_WHITE : PIX_BLACK;
         end else begin
            s3_pix_in = s2_bg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
      s1_col_ff <= s1_col_in;
      s1_row_ff <= s1_row_in;
      s1_bg_ff  <= s1_bg_in;
      s2_hit_ff <= s2_hit_in;
      s2_dx_ff  <= s2_dx_in;
      s2_dy_ff  <= s2_dy_in;
      s2_bg_ff  <= s2_bg_in;
      s3_cov_ff <= s3_cov_in;
      s3_pix_ff <= s3_pix_in;
   end

   assign rsp_ch.valid     = s3_v_ff;
   assign rsp_ch.pixel_out = s3_pix_ff;
   assign rsp_ch.covered   = s3_cov_ff;

`ifndef NO_ASSERTIONS
   // drawn pixels are pure white or pure black
   a_cov_color: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && s3_cov_ff) |-> (s3_pix_ff == PIX_WHITE || s3_pix_ff == PIX_BLACK))
      else $error("covered pixel is neither white nor black");

   // full pipeline behind a stalled output refuses new requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && s3_v_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request taken while pipeline full and stalled");

   // a waiting stage 2 result moves up as the output drains
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && rsp_ch.ready && s2_v_ff) |=> s3_v_ff)
      else $error("output bubble while stage 2 held a request");

   // origin never sits further left or up than the largest hotspot allows
   a_org_range: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((!org_x_ff[ORG_BITS-1] || org_x_ff[ORG_BITS-2:HOT_BITS] == '1) &&
                (!org_y_ff[ORG_BITS-1] || org_y_ff[ORG_BITS-2:HOT_BITS] == '1)))
      else $error("window origin out of range");
`endif

endmodule
